// ----- hw/rtl/ffbt_pkg.sv -----
// shared constants and types of the first-fit boundary-tag allocator
package ffbt_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;

  // one tag word per 4 heap bytes, chunks carry a header and a footer tag
  localparam int unsigned TAG_BYTES  = 4;
  localparam int unsigned IDX_SHIFT  = 2;
  localparam int unsigned PAIR_BYTES = 8;
  localparam int unsigned GRAN_SHIFT = 3;

  // transaction field widths
  localparam int unsigned REQ_W      = 17;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_FREE   = 1'b1;
  localparam logic TAG_FREE   = 1'b0;
  localparam logic TAG_USED   = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_WALK_CHK,
    S_SPLIT_A,
    S_SPLIT_B,
    S_SPLIT_C,
    S_APPEND,
    S_APPEND_FT,
    S_F_RD,
    S_F_CLR,
    S_F_PREV,
    S_F_MERGE,
    S_F_FOOT,
    S_F_TOP,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/ffbt_ram.sv -----
// generic single-clock ram with one write port and one registered read port
module ffbt_ram #(
  parameter int unsigned WIDTH = ffbt_pkg::ADDR_W,
  parameter int unsigned DEPTH = ffbt_pkg::HEAP_BYTES_DEF / ffbt_pkg::TAG_BYTES,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ffbt_ctrl.sv -----
// sequencer for allocate and free: walks, splits and merges chunks in the tag ram
module ffbt_ctrl #(
  parameter int unsigned HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF,
  localparam int unsigned OFF_W     = $clog2(HEAP_BYTES + 1),
  localparam int unsigned SZG_W     = OFF_W - 2,
  localparam int unsigned TAG_W     = SZG_W + 1,
  localparam int unsigned TAG_WORDS = HEAP_BYTES / ffbt_pkg::TAG_BYTES,
  localparam int unsigned IDX_W     = $clog2(TAG_WORDS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [ffbt_pkg::REQ_W-1:0]    in_req,
  input  logic [ffbt_pkg::ADDR_W-1:0]   in_addr,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [ffbt_pkg::ADDR_W-1:0]   res_addr,
  output logic                          res_status,
  output logic                          ram_we,
  output logic [IDX_W-1:0]              ram_waddr,
  output logic [TAG_W-1:0]              ram_wdata,
  output logic                          ram_re,
  output logic [IDX_W-1:0]              ram_raddr,
  input  logic [TAG_W-1:0]              ram_rdata
);

  localparam int unsigned NG_W   = ffbt_pkg::REQ_W - ffbt_pkg::GRAN_SHIFT + 1;
  localparam int unsigned NEED_W = NG_W + ffbt_pkg::GRAN_SHIFT;
  localparam int unsigned M_W    = (OFF_W + 1 > NEED_W) ? OFF_W + 1 : NEED_W;
  // offsets carry a sign bit so that underflow below the base is seen
  localparam int unsigned EXT_W  = M_W + 2;
  localparam int unsigned CMP_W  = ((SZG_W > NG_W) ? SZG_W : NG_W) + 1;

  localparam logic [EXT_W-1:0] TAG_OFF  = EXT_W'(ffbt_pkg::TAG_BYTES);
  localparam logic [EXT_W-1:0] PAIR_OFF = EXT_W'(ffbt_pkg::PAIR_BYTES);
  localparam logic [EXT_W-1:0] HEAP_END = EXT_W'(HEAP_BYTES);
  localparam logic [EXT_W-ffbt_pkg::IDX_SHIFT-1:0] WORDS =
    (EXT_W - ffbt_pkg::IDX_SHIFT)'(TAG_WORDS);
  localparam logic [ffbt_pkg::REQ_W:0] ROUND_UP =
    (ffbt_pkg::REQ_W + 1)'((1 << ffbt_pkg::GRAN_SHIFT) - 1);

  function automatic logic [EXT_W-1:0] g2b(input logic [SZG_W-1:0] g);
    g2b = EXT_W'({g, {ffbt_pkg::GRAN_SHIFT{1'b0}}});
  endfunction

  function automatic logic in_rng(input logic [EXT_W-1:0] off);
    in_rng = !off[EXT_W-1] && (off[EXT_W-1:ffbt_pkg::IDX_SHIFT] < WORDS);
  endfunction

  function automatic logic [IDX_W-1:0] idx(input logic [EXT_W-1:0] off);
    idx = off[IDX_W+ffbt_pkg::IDX_SHIFT-1:ffbt_pkg::IDX_SHIFT];
  endfunction

  ffbt_pkg::state_t state_r, state_nxt;

  logic [OFF_W-1:0]            top_r, top_nxt;
  logic                        rd_ok_r;
  logic [EXT_W-1:0]            c_r, c_nxt;
  logic [EXT_W-1:0]            prev_r, prev_nxt;
  logic [NG_W-1:0]             needg_r, needg_nxt;
  logic [SZG_W-1:0]            csg_r, csg_nxt;
  logic [SZG_W-1:0]            psg_r, psg_nxt;
  logic [ffbt_pkg::ADDR_W-1:0] p_r, p_nxt;
  logic [ffbt_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic                        res_status_r, res_status_nxt;

  logic                        rd_req, wr_req;
  logic [EXT_W-1:0]            rd_off, wr_off;
  logic [TAG_W-1:0]            wr_tag;

  // tag read back from ram, zero outside the heap
  logic [TAG_W-1:0]            rtag;
  logic [SZG_W-1:0]            rsz;
  logic                        rused;

  logic                        walk_more, fit, split, oom, top_hit;
  logic [SZG_W-1:0]            rem_g, merge_g, need_g;
  logic [EXT_W-1:0]            need_b, nc_off, fo_off, fn_off, ap_end, ap_ft;
  logic [EXT_W-1:0]            hm4_off, prev_off, foot_off, next_c, c_pay, top_pay, top_ext;
  logic [ffbt_pkg::REQ_W:0]    req_sum;

  assign rtag  = rd_ok_r ? ram_rdata : '0;
  assign rsz   = rtag[TAG_W-1:1];
  assign rused = rtag[0];

  assign top_ext   = EXT_W'(top_r);
  assign need_b    = EXT_W'({needg_r, {ffbt_pkg::GRAN_SHIFT{1'b0}}});
  assign need_g    = SZG_W'(needg_r);
  assign walk_more = c_r < top_ext;
  assign fit       = (rused == ffbt_pkg::TAG_FREE) && (CMP_W'(rsz) >= CMP_W'(needg_r));
  assign split     = CMP_W'(rsz) > (CMP_W'(needg_r) + CMP_W'(1));
  assign rem_g     = SZG_W'(CMP_W'(csg_r) - CMP_W'(needg_r) - CMP_W'(1));
  assign merge_g   = SZG_W'((SZG_W + 1)'(psg_r) + (SZG_W + 1)'(csg_r) + (SZG_W + 1)'(1));
  assign nc_off    = c_r + need_b + PAIR_OFF;
  assign fo_off    = c_r + g2b(csg_r) + TAG_OFF;
  assign fn_off    = c_r + need_b + TAG_OFF;
  assign ap_end    = top_ext + need_b + PAIR_OFF;
  assign ap_ft     = top_ext + need_b + TAG_OFF;
  assign oom       = ap_end > HEAP_END;
  assign hm4_off   = c_r - TAG_OFF;
  assign prev_off  = c_r - g2b(rsz) - PAIR_OFF;
  assign foot_off  = EXT_W'(p_r) + g2b(csg_r);
  assign next_c    = c_r + g2b(rsz) + PAIR_OFF;
  assign c_pay     = c_r + TAG_OFF;
  assign top_pay   = top_ext + TAG_OFF;
  assign req_sum   = (ffbt_pkg::REQ_W + 1)'(in_req) + ROUND_UP;
  assign top_hit   = !c_r[EXT_W-1] && (c_r < top_ext)
                     && ((c_r + g2b(csg_r) + PAIR_OFF) == top_ext);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffbt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == ffbt_pkg::CMD_ALLOC) ? ffbt_pkg::S_WALK : ffbt_pkg::S_F_RD;
        end
      end
      ffbt_pkg::S_WALK:      state_nxt = walk_more ? ffbt_pkg::S_WALK_CHK : ffbt_pkg::S_APPEND;
      ffbt_pkg::S_WALK_CHK: begin
        if (fit) begin
          state_nxt = split ? ffbt_pkg::S_SPLIT_A : ffbt_pkg::S_DONE;
        end else begin
          state_nxt = ffbt_pkg::S_WALK;
        end
      end
      ffbt_pkg::S_SPLIT_A:   state_nxt = ffbt_pkg::S_SPLIT_B;
      ffbt_pkg::S_SPLIT_B:   state_nxt = ffbt_pkg::S_SPLIT_C;
      ffbt_pkg::S_SPLIT_C:   state_nxt = ffbt_pkg::S_DONE;
      ffbt_pkg::S_APPEND:    state_nxt = oom ? ffbt_pkg::S_DONE : ffbt_pkg::S_APPEND_FT;
      ffbt_pkg::S_APPEND_FT: state_nxt = ffbt_pkg::S_DONE;
      ffbt_pkg::S_F_RD:      state_nxt = ffbt_pkg::S_F_CLR;
      ffbt_pkg::S_F_CLR:     state_nxt = (c_r == '0) ? ffbt_pkg::S_F_TOP : ffbt_pkg::S_F_PREV;
      ffbt_pkg::S_F_PREV:    state_nxt = ffbt_pkg::S_F_MERGE;
      ffbt_pkg::S_F_MERGE: begin
        state_nxt = (rused == ffbt_pkg::TAG_FREE) ? ffbt_pkg::S_F_FOOT : ffbt_pkg::S_F_TOP;
      end
      ffbt_pkg::S_F_FOOT:    state_nxt = ffbt_pkg::S_F_TOP;
      ffbt_pkg::S_F_TOP:     state_nxt = ffbt_pkg::S_DONE;
      ffbt_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = ffbt_pkg::S_IDLE;
        end
      end
      default:               state_nxt = ffbt_pkg::S_IDLE;
    endcase
  end

  // tag ram requests
  always_comb begin
    rd_req = 1'b0;
    rd_off = c_r;
    wr_req = 1'b0;
    wr_off = c_r;
    wr_tag = '0;
    case (state_r)
      ffbt_pkg::S_WALK: begin
        rd_req = walk_more;
      end
      ffbt_pkg::S_WALK_CHK: begin
        wr_req = fit;
        wr_tag = {split ? need_g : rsz, ffbt_pkg::TAG_USED};
      end
      ffbt_pkg::S_SPLIT_A: begin
        wr_req = 1'b1;
        wr_off = nc_off;
        wr_tag = {rem_g, ffbt_pkg::TAG_FREE};
        rd_req = 1'b1;
        rd_off = fo_off;
      end
      ffbt_pkg::S_SPLIT_B: begin
        // footers keep whatever status bit the word already had
        wr_req = 1'b1;
        wr_off = fo_off;
        wr_tag = {rem_g, rused};
        rd_req = 1'b1;
        rd_off = fn_off;
      end
      ffbt_pkg::S_SPLIT_C: begin
        wr_req = 1'b1;
        wr_off = fn_off;
        wr_tag = {need_g, rused};
      end
      ffbt_pkg::S_APPEND: begin
        wr_req = !oom;
        wr_off = top_ext;
        wr_tag = {need_g, ffbt_pkg::TAG_USED};
        rd_req = !oom;
        rd_off = ap_ft;
      end
      ffbt_pkg::S_APPEND_FT: begin
        wr_req = 1'b1;
        wr_off = ap_ft;
        wr_tag = {need_g, rused};
      end
      ffbt_pkg::S_F_RD: begin
        rd_req = 1'b1;
      end
      ffbt_pkg::S_F_CLR: begin
        wr_req = 1'b1;
        wr_tag = {rsz, ffbt_pkg::TAG_FREE};
        rd_req = (c_r != '0);
        rd_off = hm4_off;
      end
      ffbt_pkg::S_F_PREV: begin
        rd_req = 1'b1;
        rd_off = prev_off;
      end
      ffbt_pkg::S_F_MERGE: begin
        wr_req = (rused == ffbt_pkg::TAG_FREE);
        wr_off = prev_r;
        wr_tag = {merge_g, ffbt_pkg::TAG_FREE};
        rd_req = (rused == ffbt_pkg::TAG_FREE);
        rd_off = foot_off;
      end
      ffbt_pkg::S_F_FOOT: begin
        wr_req = 1'b1;
        wr_off = foot_off;
        wr_tag = {psg_r, rused};
      end
      default: begin
        rd_req = 1'b0;
      end
    endcase
  end

  // accesses outside the heap are dropped and read back as zero
  assign ram_we    = wr_req && in_rng(wr_off);
  assign ram_waddr = idx(wr_off);
  assign ram_wdata = wr_tag;
  assign ram_re    = rd_req && in_rng(rd_off);
  assign ram_raddr = idx(rd_off);

  assign in_ready   = (state_r == ffbt_pkg::S_IDLE);
  assign res_valid  = (state_r == ffbt_pkg::S_DONE);
  assign res_addr   = res_addr_r;
  assign res_status = res_status_r;

  // working registers
  always_comb begin
    top_nxt        = top_r;
    c_nxt          = c_r;
    prev_nxt       = prev_r;
    needg_nxt      = needg_r;
    csg_nxt        = csg_r;
    psg_nxt        = psg_r;
    p_nxt          = p_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    case (state_r)
      ffbt_pkg::S_IDLE: begin
        if (in_valid) begin
          needg_nxt = req_sum[ffbt_pkg::REQ_W:ffbt_pkg::GRAN_SHIFT];
          p_nxt     = in_addr;
          c_nxt     = (in_cmd == ffbt_pkg::CMD_ALLOC) ? '0 : (EXT_W'(in_addr) - TAG_OFF);
        end
      end
      ffbt_pkg::S_WALK_CHK: begin
        if (fit) begin
          csg_nxt        = rsz;
          res_addr_nxt   = c_pay[ffbt_pkg::ADDR_W-1:0];
          res_status_nxt = ffbt_pkg::STATUS_OK;
        end else begin
          c_nxt = next_c;
        end
      end
      ffbt_pkg::S_APPEND: begin
        if (oom) begin
          res_addr_nxt   = '0;
          res_status_nxt = ffbt_pkg::STATUS_OOM;
        end else begin
          res_addr_nxt   = top_pay[ffbt_pkg::ADDR_W-1:0];
          res_status_nxt = ffbt_pkg::STATUS_OK;
        end
      end
      ffbt_pkg::S_APPEND_FT: begin
        top_nxt = ap_end[OFF_W-1:0];
      end
      ffbt_pkg::S_F_CLR: begin
        csg_nxt = rsz;
      end
      ffbt_pkg::S_F_PREV: begin
        psg_nxt  = rsz;
        prev_nxt = prev_off;
      end
      ffbt_pkg::S_F_MERGE: begin
        // merged size as the predecessor header now reads back
        if (rused == ffbt_pkg::TAG_FREE) begin
          psg_nxt = in_rng(prev_r) ? merge_g : '0;
        end
      end
      ffbt_pkg::S_F_FOOT: begin
        c_nxt   = prev_r;
        csg_nxt = psg_r;
      end
      ffbt_pkg::S_F_TOP: begin
        if (top_hit) begin
          top_nxt = c_r[OFF_W-1:0];
        end
        res_addr_nxt   = '0;
        res_status_nxt = ffbt_pkg::STATUS_OK;
      end
      default: begin
        top_nxt = top_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffbt_pkg::S_IDLE;
      top_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      rd_ok_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    c_r          <= c_nxt;
    prev_r       <= prev_nxt;
    needg_r      <= needg_nxt;
    csg_r        <= csg_nxt;
    psg_r        <= psg_nxt;
    p_r          <= p_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule

// ----- hw/rtl/first_fit_boundary_tag_allocator.sv -----
// top level of the first-fit boundary-tag heap allocator
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in      | in  | in_tvalid/in_tready  | tuser: cmd; tdata: request_bytes, payload_address
//  out     | out | out_tvalid/out_tready| tdata: result_address; tuser: result_status
//
//  one transaction at a time; the tag ram has one write and one read port
//  allocate: walks the chunks from the base, then splits a fitting chunk, takes it whole or appends at the top
//  free: clears the header, then merges with a free predecessor found through its footer
//  reset clears heap_top and the state; the tag ram is never cleared, stale words only feed
//  footer status bits, which no walk or merge looks at
//  a result waits in the output register, so the next transaction is taken meanwhile
module first_fit_boundary_tag_allocator #(
  parameter int unsigned HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [16:0] request_bytes, [32:17] payload_address, [39:33] zero
  input  logic [ffbt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] cmd
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] result_address
  output logic [ffbt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] result_status
  output logic                              out_tuser
);

  localparam int unsigned OFF_W     = $clog2(HEAP_BYTES + 1);
  localparam int unsigned TAG_W     = OFF_W - 1;
  localparam int unsigned TAG_WORDS = HEAP_BYTES / ffbt_pkg::TAG_BYTES;
  localparam int unsigned IDX_W     = $clog2(TAG_WORDS);

  logic                        res_valid, res_ready, res_status;
  logic [ffbt_pkg::ADDR_W-1:0] res_addr;
  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  logic [TAG_W-1:0]            ram_wdata, ram_rdata;

  logic                        out_valid_r;
  logic [ffbt_pkg::ADDR_W-1:0] out_addr_r;
  logic                        out_status_r;

  ffbt_ctrl #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_req     (in_tdata[ffbt_pkg::REQ_W-1:0]),
    .in_addr    (in_tdata[ffbt_pkg::REQ_W+ffbt_pkg::ADDR_W-1:ffbt_pkg::REQ_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_addr   (res_addr),
    .res_status (res_status),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  ffbt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TAG_WORDS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: refills as soon as the held transaction leaves
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_addr_r   <= res_addr;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

endmodule
